FILE: hdl/affine_orthogonality_gradient_unit_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef AFFINE_ORTHOGONALITY_GRADIENT_UNIT_ASSERT_SVH
`define AFFINE_ORTHOGONALITY_GRADIENT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AOGU_ASSERT_NOW(lbl, clk, rst_n, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AOGU_ASSERT_NEXT(lbl, clk, rst_n, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed");

`endif

FILE: hdl/aogu_pkg.sv
package aogu_pkg;

  localparam int CompW = 32;
  localparam int ProdW = 64;
  localparam int DotW  = 67;
  localparam int PpW   = 65;
  localparam int SumW  = 101;
  localparam int SpW   = 66;
  localparam int WideW = 168;
  localparam int GradW = 48;

  localparam logic REG_STIFFNESS = 1'b0;
  localparam logic REG_VOLUME    = 1'b1;

  localparam logic [31:0] STIFFNESS_RESET = 32'd0;
  localparam logic [31:0] VOLUME_RESET    = 32'h0001_0000;

  typedef logic [2:0][2:0][CompW-1:0] mat_t;
  typedef logic [2:0][2:0][DotW-1:0]  dmat_t;
  typedef logic [2:0][2:0][SumW-1:0]  smat_t;
  typedef logic [2:0][2:0][GradW-1:0] gmat_t;

  typedef struct packed {
    logic s7;
    logic s6;
    logic s5;
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } en_t;

endpackage

FILE: hdl/aogu_in_if.sv
interface aogu_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] col0_x;
  logic signed [31:0] col0_y;
  logic signed [31:0] col0_z;
  logic signed [31:0] col1_x;
  logic signed [31:0] col1_y;
  logic signed [31:0] col1_z;
  logic signed [31:0] col2_x;
  logic signed [31:0] col2_y;
  logic signed [31:0] col2_z;

  modport source(output valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
                 col2_x, col2_y, col2_z, input ready);
  modport sink(input valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
               col2_x, col2_y, col2_z, output ready);
endinterface

FILE: hdl/aogu_out_if.sv
interface aogu_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] grad0_x;
  logic signed [47:0] grad0_y;
  logic signed [47:0] grad0_z;
  logic signed [47:0] grad1_x;
  logic signed [47:0] grad1_y;
  logic signed [47:0] grad1_z;
  logic signed [47:0] grad2_x;
  logic signed [47:0] grad2_y;
  logic signed [47:0] grad2_z;
  logic               saturated;

  modport source(output valid, grad0_x, grad0_y, grad0_z, grad1_x, grad1_y, grad1_z,
                 grad2_x, grad2_y, grad2_z, saturated, input ready);
  modport sink(input valid, grad0_x, grad0_y, grad0_z, grad1_x, grad1_y, grad1_z,
               grad2_x, grad2_y, grad2_z, saturated, output ready);
endinterface

FILE: hdl/aogu_cfg.sv
module aogu_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [63:0] scale_o
);

  logic [31:0] stiffness_q;
  logic [31:0] volume_q;
  logic [63:0] scale_q;
  logic        wr_en;
  logic        idx;

  assign idx    = paddr[2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiffness_q <= aogu_pkg::STIFFNESS_RESET;
      volume_q    <= aogu_pkg::VOLUME_RESET;
      scale_q     <= '0;
    end else begin
      if (wr_en && idx == aogu_pkg::REG_STIFFNESS) stiffness_q <= pwdata;
      if (wr_en && idx == aogu_pkg::REG_VOLUME)    volume_q    <= pwdata;
      // The product follows the registers in the next cycle, long before
      // an item reaches the stage that uses it.
      scale_q <= stiffness_q * volume_q;
    end
  end

  always_comb begin
    case (idx)
      aogu_pkg::REG_STIFFNESS: prdata = stiffness_q;
      aogu_pkg::REG_VOLUME:    prdata = volume_q;
      default:                 prdata = '0;
    endcase
  end

  assign scale_o = scale_q;

endmodule

FILE: hdl/aogu_front.sv
module aogu_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  aogu_pkg::en_t  en_i,
  input  aogu_pkg::mat_t a_i,
  output aogu_pkg::mat_t a_o,
  output aogu_pkg::dmat_t dot_o
);

  localparam logic signed [aogu_pkg::DotW-1:0] One =
    aogu_pkg::DotW'(1) <<< (2 * FRAC_BITS);

  aogu_pkg::mat_t a1_q, a2_q;
  logic signed [aogu_pkg::ProdW-1:0] prod_q [3][3][3];
  aogu_pkg::dmat_t dot_q, dot_d;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      a1_q <= a_i;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int c = 0; c < 3; c++) begin
            prod_q[i][j][c] <= $signed(a_i[i][c]) * $signed(a_i[j][c]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        dot_d[i][j] = aogu_pkg::DotW'(prod_q[i][j][0]) + aogu_pkg::DotW'(prod_q[i][j][1])
                    + aogu_pkg::DotW'(prod_q[i][j][2]);
        // The diagonal carries |a_i|^2 - 1 at the dot-product scale.
        if (i == j) dot_d[i][j] = $signed(dot_d[i][j]) - One;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      a2_q  <= a1_q;
      dot_q <= dot_d;
    end
  end

  assign a_o   = a2_q;
  assign dot_o = dot_q;

endmodule

FILE: hdl/aogu_comb.sv
module aogu_comb (
  input  logic            clk_i,
  input  aogu_pkg::en_t   en_i,
  input  aogu_pkg::mat_t  a_i,
  input  aogu_pkg::dmat_t dot_i,
  output aogu_pkg::smat_t s_o
);

  logic signed [aogu_pkg::PpW-1:0] pp_q [3][3][3][3];
  aogu_pkg::smat_t s_q, s_d;

  // Each 67-bit dot product is split into two unsigned 32-bit limbs and a
  // signed top limb so that no multiplier exceeds 33 by 32 bits.
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          for (int j = 0; j < 3; j++) begin
            pp_q[i][c][j][0] <= $signed({1'b0, dot_i[j][i][31:0]}) * $signed(a_i[j][c]);
            pp_q[i][c][j][1] <= $signed({1'b0, dot_i[j][i][63:32]}) * $signed(a_i[j][c]);
            pp_q[i][c][j][2] <= $signed(dot_i[j][i][66:64]) * $signed(a_i[j][c]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        s_d[i][c] = '0;
        for (int j = 0; j < 3; j++) begin
          s_d[i][c] = $signed(s_d[i][c]) + aogu_pkg::SumW'(pp_q[i][c][j][0])
                    + (aogu_pkg::SumW'(pp_q[i][c][j][1]) <<< 32)
                    + (aogu_pkg::SumW'(pp_q[i][c][j][2]) <<< 64);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) s_q <= s_d;
  end

  assign s_o = s_q;

endmodule

FILE: hdl/aogu_back.sv
module aogu_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  aogu_pkg::en_t   en_i,
  input  aogu_pkg::smat_t s_i,
  input  logic [63:0]     scale_i,
  output aogu_pkg::gmat_t grad_o,
  output logic            sat_o
);

  localparam logic signed [aogu_pkg::WideW-1:0] Half =
    aogu_pkg::WideW'(1) <<< (3 * FRAC_BITS - 1);

  logic signed [aogu_pkg::SpW-1:0]   sp_q [3][3][4][2];
  logic signed [aogu_pkg::WideW-1:0] p_q  [3][3];
  logic signed [aogu_pkg::WideW-1:0] p_d  [3][3];
  logic signed [aogu_pkg::WideW-1:0] rnd  [3][3];
  logic signed [aogu_pkg::WideW-1:0] r    [3][3];
  aogu_pkg::gmat_t grad_q, grad_d;
  logic            sat_q, sat_d;

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          for (int n = 0; n < 2; n++) begin
            for (int m = 0; m < 3; m++) begin
              sp_q[i][c][m][n] <= $signed({1'b0, s_i[i][c][32*m +: 32]})
                                * $signed({1'b0, scale_i[32*n +: 32]});
            end
            sp_q[i][c][3][n] <= $signed(s_i[i][c][100:96])
                              * $signed({1'b0, scale_i[32*n +: 32]});
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        p_d[i][c] = '0;
        for (int m = 0; m < 4; m++) begin
          for (int n = 0; n < 2; n++) begin
            p_d[i][c] = p_d[i][c]
                      + (aogu_pkg::WideW'(sp_q[i][c][m][n]) <<< (32 * (m + n)));
          end
        end
        // The factor four of the gradient.
        p_d[i][c] = p_d[i][c] <<< 2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s6) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) p_q[i][c] <= p_d[i][c];
      end
    end
  end

  always_comb begin
    sat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        rnd[i][c] = p_q[i][c] + Half;
        r[i][c]   = rnd[i][c] >>> (3 * FRAC_BITS);
        if ((&r[i][c][167:47]) || !(|r[i][c][167:47])) begin
          grad_d[i][c] = r[i][c][47:0];
        end else begin
          sat_d = 1'b1;
          grad_d[i][c] = r[i][c][167] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s7) begin
      grad_q <= grad_d;
      sat_q  <= sat_d;
    end
  end

  assign grad_o = grad_q;
  assign sat_o  = sat_q;

endmodule

FILE: hdl/affine_orthogonality_gradient_unit.sv
// Affine orthogonality gradient unit.
// The input channel carries the three columns of a body's 3x3 affine matrix
// in signed fixed point; the output channel returns the nine gradient
// components in signed Q32.16 and a flag that is set when any component was
// clamped. The user writes stiffness and body volume over the APB port, at
// byte addresses 0 and 4, only while the block is idle; nothing enforces it.
// The datapath is a seven-stage pipeline: column products, dot products,
// dot-by-column partial products, column sums, partial products with the
// scale, the wide sum, then rounding and clamping into the output register.
// One request is taken every cycle until a stalled receiver has filled the
// pipeline; the 32-bit multiplier stages accept new operands every clock
// in which their stage may load.
// Reset empties the pipeline and loads stiffness 0 and volume 1.0.
// When the receiver stalls, results stay in their stages and empty stages
// below them still fill, so requests keep being accepted until the
// pipeline is full.
module affine_orthogonality_gradient_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aogu_in_if.sink     in_i,
  aogu_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:1]      v_q;
  logic [8:1]      en;
  aogu_pkg::en_t   en_s;
  aogu_pkg::mat_t  a_in, a_mid;
  aogu_pkg::dmat_t dot;
  aogu_pkg::smat_t s;
  aogu_pkg::gmat_t grad;
  logic [63:0]     scale;
  logic            sat;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[8] = out_o.ready;
    for (int k = 7; k >= 1; k--) en[k] = !v_q[k] || en[k+1];
  end

  assign en_s       = aogu_pkg::en_t'(en[7:1]);
  assign in_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_i.valid;
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign a_in[0][0] = in_i.col0_x;
  assign a_in[0][1] = in_i.col0_y;
  assign a_in[0][2] = in_i.col0_z;
  assign a_in[1][0] = in_i.col1_x;
  assign a_in[1][1] = in_i.col1_y;
  assign a_in[1][2] = in_i.col1_z;
  assign a_in[2][0] = in_i.col2_x;
  assign a_in[2][1] = in_i.col2_y;
  assign a_in[2][2] = in_i.col2_z;

  aogu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .scale_o (scale)
  );

  aogu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i (clk_i),
    .en_i  (en_s),
    .a_i   (a_in),
    .a_o   (a_mid),
    .dot_o (dot)
  );

  aogu_comb u_comb (
    .clk_i (clk_i),
    .en_i  (en_s),
    .a_i   (a_mid),
    .dot_i (dot),
    .s_o   (s)
  );

  aogu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .en_i    (en_s),
    .s_i     (s),
    .scale_i (scale),
    .grad_o  (grad),
    .sat_o   (sat)
  );

  assign out_o.valid     = v_q[7];
  assign out_o.grad0_x   = grad[0][0];
  assign out_o.grad0_y   = grad[0][1];
  assign out_o.grad0_z   = grad[0][2];
  assign out_o.grad1_x   = grad[1][0];
  assign out_o.grad1_y   = grad[1][1];
  assign out_o.grad1_z   = grad[1][2];
  assign out_o.grad2_x   = grad[2][0];
  assign out_o.grad2_y   = grad[2][1];
  assign out_o.grad2_z   = grad[2][2];
  assign out_o.saturated = sat;

endmodule

FILE: hdl/aogu_checker.sv
`include "affine_orthogonality_gradient_unit_assert.svh"

module aogu_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_ready_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input logic [432:0] out_data_i,
  input logic         psel_i,
  input logic         penable_i,
  input logic         pwrite_i,
  input logic [2:0]   paddr_i,
  input logic [31:0]  pwdata_i,
  input logic [31:0]  prdata_i
);

  // With no result waiting, every stage is free to move, so a request is taken.
  `AOGU_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // A written register reads back the written value at the same address.
  `AOGU_ASSERT_NEXT(a_cfg_readback, clk_i, rst_ni, psel_i && penable_i && pwrite_i, (paddr_i != $past(paddr_i)) || (prdata_i == $past(pwdata_i)))

  `AOGU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  `AOGU_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i))

endmodule

bind affine_orthogonality_gradient_unit aogu_checker u_aogu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  ({out_o.grad0_x, out_o.grad0_y, out_o.grad0_z, out_o.grad1_x,
                 out_o.grad1_y, out_o.grad1_z, out_o.grad2_x, out_o.grad2_y,
                 out_o.grad2_z, out_o.saturated}),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);
